[hdl/sbif_pkg.sv]
// Shared types and constants for the selectable bilinear IIR filter core.
// Used by the divider, the coefficient sequencer, the filter datapath and the top level.
package sbif_pkg;

  localparam int CW = 30;   // coefficient width, Q2.28 saturated
  localparam int SW = 44;   // width of the coefficient set-up arithmetic
  localparam int QW = 30;   // divider quotient width
  localparam int DW = 24;   // dividend bits shifted into the divider
  localparam int YW = 28;   // output history width, Q.12 saturated
  localparam int XW = 24;   // input history width, Q.12
  localparam int AW = 64;   // accumulator width

  localparam logic [16:0] FS2  = 17'd88200;          // 2 * sample rate
  localparam logic [32:0] FSQ4 = 33'd7779240000;     // 4 * sample rate squared
  localparam logic [11:0] KNOB_SCALE = 12'd2695;
  localparam logic [12:0] KNOB_OFFSET = 13'd408;
  localparam logic [SW-1:0] KNOB_DIV = SW'(4095);

  localparam logic signed [CW-1:0] CMAX = 30'sh1FFFFFFF;
  localparam logic signed [CW-1:0] CMIN = 30'sh20000000;

  localparam logic [2:0] MODE_PASS  = 3'd0;
  localparam logic [2:0] MODE_LP    = 3'd1;
  localparam logic [2:0] MODE_HP    = 3'd2;
  localparam logic [2:0] MODE_BP    = 3'd3;
  localparam logic [2:0] MODE_NOTCH = 3'd4;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_LP_KNOB  = 3'd1;
  localparam logic [2:0] REG_HP_KNOB  = 3'd2;
  localparam logic [2:0] REG_BP_CTR   = 3'd3;
  localparam logic [2:0] REG_BP_Q     = 3'd4;
  localparam logic [2:0] REG_NT_CTR   = 3'd5;
  localparam logic [2:0] REG_NT_Q     = 3'd6;
  localparam logic [2:0] REG_GAIN     = 3'd7;

  typedef struct packed {
    logic [SW-1:0] den;
    logic [SW-1:0] rem0;
    logic [DW-1:0] dvd;
    logic [4:0]    steps;
    logic          quo0;
  } div_req_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [3:0]         gain;
    logic [4:0][CW-1:0] c;
  } filt_cfg_t;

endpackage

[hdl/sbif_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on sbif_pkg for the request type and widths.
module sbif_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sbif_pkg::div_req_t req,
  output logic              done,
  output logic [sbif_pkg::QW-1:0] quo
);
  import sbif_pkg::*;

  logic          run;
  logic [4:0]    cnt;
  logic [SW-1:0] den;
  logic [SW-1:0] r;
  logic [DW-1:0] dvd;
  logic [SW-1:0] r2;
  logic          ge;

  always_comb begin
    r2 = {r[SW-2:0], dvd[DW-1]};
    ge = (r2 >= den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= req.steps;
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= req.den;
      r   <= req.rem0;
      dvd <= req.dvd;
      quo <= {{(QW-1){1'b0}}, req.quo0};
    end else if (run) begin
      r   <= ge ? (r2 - den) : r2;
      dvd <= {dvd[DW-2:0], 1'b0};
      quo <= {quo[QW-2:0], ge};
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !run)
    else $error("divider reports done while still running");
  a_cnt_live: assert property (@(posedge clk) disable iff (rst) run |-> (cnt != 5'd0))
    else $error("divider running with an empty step count");

endmodule

[hdl/sbif_coef.sv]
// Configuration registers and the sequencer that derives the five Q2.28 coefficients.
// Depends on sbif_pkg and the shared divider sbif_div.
module sbif_coef (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 busy,
  output sbif_pkg::filt_cfg_t  cfg
);
  import sbif_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_P0     = 4'd1;
  localparam logic [3:0] S_P1     = 4'd2;
  localparam logic [3:0] S_P2     = 4'd3;
  localparam logic [3:0] S_KSTART = 4'd4;
  localparam logic [3:0] S_KWAIT  = 4'd5;
  localparam logic [3:0] S_KW     = 4'd6;
  localparam logic [3:0] S_JSEL   = 4'd7;
  localparam logic [3:0] S_DGO    = 4'd8;
  localparam logic [3:0] S_DWAIT  = 4'd9;
  localparam logic [3:0] S_DPOST  = 4'd10;

  logic [2:0]  mode;
  logic [11:0] lp_knob, hp_knob;
  logic [15:0] bp_ctr, nt_ctr;
  logic [6:0]  bp_q, nt_q;
  logic [3:0]  gain;

  logic [3:0]  st;
  logic [1:0]  job;
  logic [23:0] kp;
  logic [31:0] ww;
  logic [32:0] bw;
  logic [39:0] qf;
  logic [38:0] qww;
  logic [6:0]  q_s;
  logic [12:0] wc;
  logic [SW-1:0] a0;
  logic [2:0][SW-1:0] num;
  logic          neg;
  logic [SW-1:0] mag;
  logic [4:0][CW-1:0] c;

  logic [15:0] w_eff;
  logic [6:0]  q_eff;
  logic [11:0] k_sel;
  logic        first_order;
  logic [1:0]  last_job;
  logic        ovf, qb;
  logic        div_start, div_done;
  div_req_t    dreq;
  logic [QW-1:0] dquo;
  logic [QW-1:0] vr;
  logic signed [CW-1:0] res, res_neg;
  logic        wr;

  always_comb begin
    w_eff = (mode == MODE_BP) ? bp_ctr : nt_ctr;
    if (w_eff == 16'd0) begin
      w_eff = 16'd1;
    end
    q_eff = (mode == MODE_BP) ? bp_q : nt_q;
    if (q_eff == 7'd0) begin
      q_eff = 7'd1;
    end
    k_sel = (mode == MODE_LP) ? lp_knob : hp_knob;
    first_order = (mode == MODE_LP) || (mode == MODE_HP);
    last_job = first_order ? 2'd1 : 2'd2;
    ovf = ({1'b0, mag} >= {a0, 1'b0});
    qb  = (mag >= a0);
    if (st == S_KSTART) begin
      dreq.den   = KNOB_DIV;
      dreq.rem0  = '0;
      dreq.dvd   = kp;
      dreq.steps = 5'd24;
      dreq.quo0  = 1'b0;
    end else begin
      dreq.den   = a0;
      dreq.rem0  = qb ? (mag - a0) : mag;
      dreq.dvd   = '0;
      dreq.steps = 5'd29;
      dreq.quo0  = qb;
    end
    div_start = (st == S_KSTART) || ((st == S_DGO) && !ovf);
    vr = QW'(({1'b0, dquo} + 31'd1) >> 1);
    if (st == S_DGO) begin
      res = neg ? CMIN : CMAX;
    end else if (neg) begin
      res = -$signed(vr);
    end else begin
      res = (vr > QW'(CMAX)) ? CMAX : $signed(vr);
    end
    res_neg = -res;
    wr = ((st == S_DGO) && ovf) || (st == S_DPOST);
  end

  sbif_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (dreq),
    .done  (div_done),
    .quo   (dquo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_PASS;
      lp_knob <= 12'd0;
      hp_knob <= 12'd0;
      bp_ctr  <= 16'd628;
      bp_q    <= 7'd100;
      nt_ctr  <= 16'd628;
      nt_q    <= 7'd100;
      gain    <= 4'd7;
      st      <= S_P0;
      job     <= 2'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODE:    mode    <= cfg_data[2:0];
        REG_LP_KNOB: lp_knob <= cfg_data[11:0];
        REG_HP_KNOB: hp_knob <= cfg_data[11:0];
        REG_BP_CTR:  bp_ctr  <= cfg_data;
        REG_BP_Q:    bp_q    <= cfg_data[6:0];
        REG_NT_CTR:  nt_ctr  <= cfg_data;
        REG_NT_Q:    nt_q    <= cfg_data[6:0];
        REG_GAIN:    gain    <= cfg_data[3:0];
        default:     gain    <= gain;
      endcase
      st <= S_P0;
    end else begin
      case (st)
        S_P0: st <= S_P1;
        S_P1: st <= S_P2;
        S_P2: begin
          job <= 2'd0;
          if (first_order) begin
            st <= S_KSTART;
          end else if ((mode == MODE_BP) || (mode == MODE_NOTCH)) begin
            st <= S_JSEL;
          end else begin
            st <= S_IDLE;
          end
        end
        S_KSTART: st <= S_KWAIT;
        S_KWAIT: begin
          if (div_done) begin
            st <= S_KW;
          end
        end
        S_KW:   st <= S_JSEL;
        S_JSEL: st <= S_DGO;
        S_DGO: begin
          if (!ovf) begin
            st <= S_DWAIT;
          end else if (job == last_job) begin
            st <= S_IDLE;
          end else begin
            job <= job + 2'd1;
            st  <= S_JSEL;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            st <= S_DPOST;
          end
        end
        S_DPOST: begin
          if (job == last_job) begin
            st <= S_IDLE;
          end else begin
            job <= job + 2'd1;
            st  <= S_JSEL;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      S_P0: begin
        kp  <= {12'b0, k_sel} * {12'b0, KNOB_SCALE};
        ww  <= {16'b0, w_eff} * {16'b0, w_eff};
        bw  <= {17'b0, w_eff} * {16'b0, FS2};
        qf  <= {33'b0, q_eff} * {7'b0, FSQ4};
        q_s <= q_eff;
        c   <= '0;
      end
      S_P1: begin
        qww <= {7'b0, ww} * {32'b0, q_s};
      end
      S_P2: begin
        a0 <= SW'(qf) + SW'(bw) + SW'(qww);
        num[0] <= (mode == MODE_BP) ? SW'(bw) : (SW'(qf) + SW'(qww));
        num[1] <= SW'({qww, 1'b0}) - SW'({qf, 1'b0});
        num[2] <= SW'(qf) - SW'(bw) + SW'(qww);
      end
      S_KWAIT: begin
        wc <= 13'(dquo[11:0]) + KNOB_OFFSET;
      end
      S_KW: begin
        a0     <= SW'(wc) + SW'(FS2);
        num[0] <= (mode == MODE_LP) ? SW'(wc) : SW'(FS2);
        num[1] <= SW'(wc) - SW'(FS2);
      end
      S_JSEL: begin
        neg <= num[job][SW-1];
        mag <= num[job][SW-1] ? (SW'(0) - num[job]) : num[job];
      end
      default: begin
        if (wr) begin
          case (job)
            2'd0: begin
              c[0] <= res;
              if (mode == MODE_LP) begin
                c[1] <= res;
              end else if (mode == MODE_HP) begin
                c[1] <= res_neg;
              end else if (mode == MODE_BP) begin
                c[2] <= res_neg;
              end else begin
                c[2] <= res;
              end
            end
            2'd1: begin
              c[3] <= res;
              if (mode == MODE_NOTCH) begin
                c[1] <= res;
              end
            end
            default: c[4] <= res;
          endcase
        end
      end
    endcase
  end

  assign busy = (st != S_IDLE);
  assign cfg  = '{mode: mode, gain: gain, c: c};

  a_job_range: assert property (@(posedge clk) disable iff (rst) busy |-> (job <= 2'd2))
    else $error("coefficient job index out of range");

endmodule

[hdl/sbif_mac.sv]
// Filter datapath: one shared multiplier and accumulator run by a short sequencer.
// Holds the input and output histories; depends on sbif_pkg.
module sbif_mac (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [11:0]         sample,
  input  sbif_pkg::filt_cfg_t cfg,
  output logic                idle,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [15:0]         res_sample
);
  import sbif_pkg::*;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_MUL  = 3'd1;
  localparam logic [2:0] M_ADD  = 3'd2;
  localparam logic [2:0] M_GAIN = 3'd3;
  localparam logic [2:0] M_RND  = 3'd4;
  localparam logic [2:0] M_DONE = 3'd5;

  logic [2:0]  st;
  logic [2:0]  sel;
  logic [XW-1:0] x, x1, x2;
  logic signed [YW-1:0] y1, y2;
  logic signed [57:0] prod;
  logic signed [AW-1:0] acc;

  logic signed [CW-1:0] coef;
  logic signed [YW-1:0] op;
  logic signed [57:0]   prod_n;
  logic [4:0]           g;
  logic                 filt;
  logic signed [AW-1:0] t;
  logic signed [35:0]   ysh;
  logic signed [YW-1:0] ysat, yfin;
  logic signed [28:0]   oy, osh;
  logic signed [15:0]   osat;

  always_comb begin
    coef = $signed(cfg.c[sel]);
    case (sel)
      3'd0:    op = $signed({4'b0, x});
      3'd1:    op = $signed({4'b0, x1});
      3'd2:    op = $signed({4'b0, x2});
      3'd3:    op = y1;
      3'd4:    op = y2;
      default: op = '0;
    endcase
    prod_n = coef * op;
    filt = (cfg.mode == MODE_LP) || (cfg.mode == MODE_HP) ||
           (cfg.mode == MODE_BP) || (cfg.mode == MODE_NOTCH);
    g = ((cfg.mode == MODE_LP) || (cfg.mode == MODE_HP)) ? {1'b0, cfg.gain} : 5'd1;
    t = acc + 64'sd134217728;
    ysh = 36'(t >>> 28);
    if (ysh > 36'sd134217727) begin
      ysat = 28'sh7FFFFFF;
    end else if (ysh < -36'sd134217728) begin
      ysat = 28'sh8000000;
    end else begin
      ysat = ysh[YW-1:0];
    end
    yfin = filt ? ysat : $signed({4'b0, x});
    oy  = 29'(yfin) + 29'sd2048;
    osh = oy >>> 12;
    if (osh > 29'sd32767) begin
      osat = 16'sh7FFF;
    end else if (osh < -29'sd32768) begin
      osat = 16'sh8000;
    end else begin
      osat = osh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= M_IDLE;
      sel <= 3'd0;
      x1  <= '0;
      x2  <= '0;
      y1  <= '0;
      y2  <= '0;
    end else begin
      case (st)
        M_IDLE: begin
          if (start) begin
            sel <= 3'd0;
            st  <= M_MUL;
          end
        end
        M_MUL: st <= M_ADD;
        M_ADD: begin
          if (sel == 3'd2) begin
            st <= M_GAIN;
          end else if (sel == 3'd4) begin
            st <= M_RND;
          end else begin
            sel <= sel + 3'd1;
            st  <= M_MUL;
          end
        end
        M_GAIN: begin
          sel <= 3'd3;
          st  <= M_MUL;
        end
        M_RND: begin
          x1 <= x;
          x2 <= x1;
          y1 <= yfin;
          y2 <= y1;
          st <= M_DONE;
        end
        M_DONE: begin
          if (res_ready) begin
            st <= M_IDLE;
          end
        end
        default: st <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      M_IDLE: begin
        x   <= {sample, 12'b0};
        acc <= '0;
      end
      M_MUL:  prod <= prod_n;
      M_ADD:  acc <= (sel < 3'd3) ? (acc + 64'(prod)) : (acc - 64'(prod));
      M_GAIN: acc <= acc * $signed(g);
      M_RND:  res_sample <= osat;
      default: acc <= acc;
    endcase
  end

  assign idle      = (st == M_IDLE);
  assign res_valid = (st == M_DONE);

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> (st == M_IDLE))
    else $error("sample started while the datapath is busy");
  a_sel_range: assert property (@(posedge clk) disable iff (rst)
      (st == M_MUL) |-> (sel <= 3'd4))
    else $error("multiplier operand select out of range");

endmodule

[hdl/selectable_bilinear_iir_filter_core.sv]
// Each input passes multiply-accumulate, gain and rounding before the output register.
// A new sample is taken only when the single shared multiplier and accumulator are idle.
// Reset and every register write start a coefficient recomputation on the shared divider;
// no input is taken until it has finished.
// Reset is synchronous: histories clear and the registers take their default values.
module selectable_bilinear_iir_filter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample_in, [15:12] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample_out
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sbif_pkg::*;

  filt_cfg_t   cfg;
  logic        coef_busy;
  logic        mac_idle;
  logic        res_valid;
  logic        res_ready;
  logic [15:0] res_sample;
  logic        in_xfer;

  assign s_tready  = mac_idle && !coef_busy && !cfg_wr_en;
  assign in_xfer   = s_tvalid && s_tready;
  assign res_ready = !m_tvalid || m_tready;

  sbif_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (coef_busy),
    .cfg       (cfg)
  );

  sbif_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .start      (in_xfer),
    .sample     (s_tdata[11:0]),
    .cfg        (cfg),
    .idle       (mac_idle),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_sample (res_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= res_sample;
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst) in_xfer |-> !coef_busy)
    else $error("input transfer during coefficient recomputation");

endmodule
